// File: design/tsc_pkg.sv
`default_nettype none
package tsc_pkg;

	localparam int NUM_CHANNELS = 64;
	localparam int SAMPLE_BITS  = 12;

	// port widths
	localparam int SAMPLE_W = 12;
	localparam int INDEX_W  = 6;
	localparam int POS_W    = 15;
	localparam int COUNT_W  = 7;
	localparam int SUM_W    = 18;

	localparam int CH_BITS      = $clog2(NUM_CHANNELS);
	localparam int IDX_BITS     = CH_BITS + 1;
	localparam int LEN_BITS     = CH_BITS + 1;
	localparam int START_BITS   = CH_BITS + 1;
	localparam int BASE_BITS    = CH_BITS + 2;
	localparam int PRESS_BITS   = SAMPLE_BITS + CH_BITS;
	localparam int WEIGHT_BITS  = SAMPLE_BITS + 2 * CH_BITS;
	localparam int FRAC_BITS    = 8;
	localparam int QUOT_BITS    = CH_BITS + FRAC_BITS;
	localparam int POS_SUM_BITS = BASE_BITS + FRAC_BITS + 1;
	localparam int CNT_BITS     = $clog2(QUOT_BITS + 1);

	typedef struct packed {
		logic [WEIGHT_BITS-1:0] weighted;
		logic [PRESS_BITS-1:0]  pressure;
		logic [LEN_BITS-1:0]    length;
		logic [BASE_BITS-1:0]   base;
	} touch_rec_t;

	typedef struct packed {
		logic valley;
		logic frame_end;
	} seg_flags_t;

endpackage
`default_nettype wire

// File: design/tsc_segmenter.sv
`default_nettype none
module tsc_segmenter import tsc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic [INDEX_W-1:0]  frame_start,
	input  logic [INDEX_W-1:0]  chan_offset,
	input  logic                last_in_frame,
	output seg_flags_t          flags,
	output touch_rec_t          rec_a,
	output touch_rec_t          rec_b
);

	logic                   in_frame_q;
	logic                   peak_held_q;
	logic [SAMPLE_BITS-1:0] peak_val_q;
	logic [IDX_BITS-1:0]    peak_pos_q;
	logic [SAMPLE_BITS-1:0] prev_q;
	logic [IDX_BITS-1:0]    idx_q;
	logic [START_BITS-1:0]  start_q;
	logic [INDEX_W-1:0]     shift_q;
	logic [PRESS_BITS-1:0]  press_q;
	logic [WEIGHT_BITS-1:0] weight_q;
	logic [LEN_BITS-1:0]    len_q;
	touch_rec_t             rec_a_q;
	touch_rec_t             rec_b_q;

	logic [SAMPLE_BITS-1:0] v;
	logic [START_BITS-1:0]  st, st2;
	logic [INDEX_W-1:0]     hs;
	logic [IDX_BITS-1:0]    idx, idx2;
	logic                   ph, ph2;
	logic [SAMPLE_BITS-1:0] pv, pv2, prv, prv2;
	logic [IDX_BITS-1:0]    pp, pp2;
	logic [PRESS_BITS-1:0]  p, p2, p3;
	logic [WEIGHT_BITS-1:0] w, w2, w3;
	logic [LEN_BITS-1:0]    l, l2, l3;
	logic [LEN_BITS+SAMPLE_BITS-1:0] prod;
	logic                   rise, valley, frame_end;

	assign v = sample[SAMPLE_BITS-1:0];

	always_comb begin
		// open a fresh frame on its first sample
		if (in_frame_q) begin
			st  = start_q;
			hs  = shift_q;
			idx = idx_q;
			ph  = peak_held_q;
			pv  = peak_val_q;
			pp  = peak_pos_q;
			prv = prev_q;
			p   = press_q;
			w   = weight_q;
			l   = len_q;
		end else begin
			st  = START_BITS'(frame_start);
			hs  = chan_offset;
			idx = '0;
			ph  = 1'b0;
			pv  = '0;
			pp  = '0;
			prv = '0;
			p   = '0;
			w   = '0;
			l   = '0;
		end

		rise   = !ph || (((pp + 1'b1) == idx) && (v >= pv));
		valley = !rise && ((pp + 1'b1) != idx) && (v > prv);

		st2  = st;
		p2   = p;
		w2   = w;
		l2   = l;
		ph2  = ph;
		pv2  = pv;
		pp2  = pp;
		prv2 = prv;
		if (rise) begin
			pv2  = v;
			pp2  = idx;
			ph2  = 1'b1;
			prv2 = v;
		end else if (valley) begin
			// valley sample opens the next segment as well
			st2  = st + START_BITS'(l) - 1'b1;
			p2   = PRESS_BITS'(prv);
			w2   = '0;
			l2   = LEN_BITS'(1);
			ph2  = 1'b0;
			pv2  = '0;
			prv2 = '0;
		end else begin
			prv2 = v;
		end

		prod = l2 * v;
		w3   = w2 + WEIGHT_BITS'(prod);
		p3   = p2 + PRESS_BITS'(v);
		l3   = l2 + 1'b1;

		idx2      = idx + 1'b1;
		frame_end = last_in_frame || (idx2 >= IDX_BITS'(NUM_CHANNELS));
	end

	assign flags.valley    = valley;
	assign flags.frame_end = frame_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q  <= 1'b0;
			peak_held_q <= 1'b0;
			peak_val_q  <= '0;
			peak_pos_q  <= '0;
			prev_q      <= '0;
			idx_q       <= '0;
			start_q     <= '0;
			shift_q     <= '0;
			press_q     <= '0;
			weight_q    <= '0;
			len_q       <= '0;
		end else if (step) begin
			in_frame_q  <= !frame_end;
			peak_held_q <= ph2;
			peak_val_q  <= pv2;
			peak_pos_q  <= pp2;
			prev_q      <= prv2;
			idx_q       <= idx2;
			start_q     <= st2;
			shift_q     <= hs;
			press_q     <= p3;
			weight_q    <= w3;
			len_q       <= l3;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			rec_a_q.weighted <= w;
			rec_a_q.pressure <= p;
			rec_a_q.length   <= l;
			rec_a_q.base     <= BASE_BITS'(st) + BASE_BITS'(hs);
			rec_b_q.weighted <= w3;
			rec_b_q.pressure <= p3;
			rec_b_q.length   <= l3;
			rec_b_q.base     <= BASE_BITS'(st2) + BASE_BITS'(hs);
		end
	end

	assign rec_a = rec_a_q;
	assign rec_b = rec_b_q;

endmodule
`default_nettype wire

// File: design/tsc_divider.sv
`default_nettype none
module tsc_divider import tsc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [WEIGHT_BITS-1:0] num,
	input  logic [PRESS_BITS-1:0]  den,
	output logic                   busy,
	output logic [QUOT_BITS-1:0]   quot
);

	logic                  busy_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [PRESS_BITS-1:0] rem_q;
	logic [QUOT_BITS-1:0]  bits_q;
	logic [PRESS_BITS-1:0] den_q;

	logic [PRESS_BITS:0]   trial;
	logic [PRESS_BITS:0]   diff;
	logic                  qbit;
	logic [PRESS_BITS-1:0] rem_nx;

	assign trial  = {rem_q, bits_q[QUOT_BITS-1]};
	assign diff   = trial - {1'b0, den_q};
	assign qbit   = !diff[PRESS_BITS];
	assign rem_nx = qbit ? diff[PRESS_BITS-1:0] : trial[PRESS_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_BITS'(QUOT_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_BITS'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// dividend is weighted << 8; its top part is already below the divisor
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num[WEIGHT_BITS-1:CH_BITS];
			bits_q <= {num[CH_BITS-1:0], {FRAC_BITS{1'b0}}};
			den_q  <= den;
		end else if (busy_q) begin
			rem_q  <= rem_nx;
			bits_q <= {bits_q[QUOT_BITS-2:0], qbit};
		end
	end

	assign busy = busy_q;
	assign quot = bits_q;

endmodule
`default_nettype wire

// File: design/touch_segment_centroid.sv
// Touch segment centroid.
// Input channel (sample_valid / sample_ready): one channel pressure per
// transaction with frame_start, chan_offset and last_in_frame; the frame
// fields are taken from the first sample of each frame.
// Output channel (touch_valid / touch_ready): one touch per transaction with
// position_q8, channel_count, pressure_sum, zero_pressure and last_of_run.
// Each input yields zero, one or two touches.
// Each touch passes through S_PICK, which loads the divider, S_DIV, which
// runs the bit-serial restoring divide of weighted << 8 by pressure (one
// quotient bit per cycle) and sees the divider finish, and S_PUT, which forms
// the position into the output register. The next input is accepted only
// once every touch of the last one has been through these states.
// The output register holds a finished touch while the next is computed;
// a stalled receiver holds the block once a second touch is ready.
// Reset clears the frame state, the pending touches and touch_valid;
// the first sample after reset opens a new frame.
`default_nettype none
module touch_segment_centroid import tsc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_ready,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic [INDEX_W-1:0]  frame_start,
	input  logic [INDEX_W-1:0]  chan_offset,
	input  logic                last_in_frame,
	output logic                touch_valid,
	input  logic                touch_ready,
	output logic [POS_W-1:0]    position_q8,
	output logic [COUNT_W-1:0]  channel_count,
	output logic [SUM_W-1:0]    pressure_sum,
	output logic                zero_pressure,
	output logic                last_of_run
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_PICK = 4'b0010,
		S_DIV  = 4'b0100,
		S_PUT  = 4'b1000
	} state_t;

	state_t     state_q;
	logic       pend_a_q;
	logic       pend_b_q;
	logic       last_q;
	touch_rec_t cur_q;

	logic                touch_valid_q;
	logic [POS_W-1:0]    position_q;
	logic [COUNT_W-1:0]  count_q;
	logic [SUM_W-1:0]    sum_q;
	logic                zero_q;
	logic                last_run_q;

	logic                 accept;
	seg_flags_t           flags;
	touch_rec_t           rec_a;
	touch_rec_t           rec_b;
	touch_rec_t           pick_rec;
	logic                 div_start;
	logic                 div_busy;
	logic [QUOT_BITS-1:0] div_quot;
	logic                 load_out;

	logic                    zero;
	logic [QUOT_BITS-1:0]    q;
	logic [POS_SUM_BITS-1:0] pos_full;
	logic [POS_SUM_BITS-1:0] pos_wrap;
	logic [POS_SUM_BITS-1:0] pos_limit;

	assign sample_ready = (state_q == S_IDLE);
	assign accept       = sample_valid && sample_ready;

	tsc_segmenter u_seg (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (accept),
		.sample        (sample),
		.frame_start   (frame_start),
		.chan_offset   (chan_offset),
		.last_in_frame (last_in_frame),
		.flags         (flags),
		.rec_a         (rec_a),
		.rec_b         (rec_b)
	);

	assign pick_rec  = pend_a_q ? rec_a : rec_b;
	assign div_start = (state_q == S_PICK) && (pend_a_q || pend_b_q);

	tsc_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (pick_rec.weighted),
		.den    (pick_rec.pressure),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	assign load_out = (state_q == S_PUT) && (!touch_valid_q || touch_ready);

	always_comb begin
		zero      = (cur_q.pressure == '0);
		q         = zero ? '0 : div_quot;
		pos_limit = POS_SUM_BITS'(NUM_CHANNELS * (1 << FRAC_BITS));
		pos_full  = POS_SUM_BITS'(q) + POS_SUM_BITS'({cur_q.base, {FRAC_BITS{1'b0}}});
		// wrap once past the last channel
		pos_wrap  = (pos_full >= pos_limit) ? (pos_full - pos_limit) : pos_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			pend_a_q <= 1'b0;
			pend_b_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						pend_a_q <= flags.valley;
						pend_b_q <= flags.frame_end;
						state_q  <= S_PICK;
					end
				end
				S_PICK: begin
					if (pend_a_q) begin
						pend_a_q <= 1'b0;
						state_q  <= S_DIV;
					end else if (pend_b_q) begin
						pend_b_q <= 1'b0;
						state_q  <= S_DIV;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_DIV: begin
					if (!div_busy) begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					if (load_out) begin
						state_q <= S_PICK;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			cur_q  <= pick_rec;
			last_q <= !(pend_a_q && pend_b_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touch_valid_q <= 1'b0;
		end else if (load_out) begin
			touch_valid_q <= 1'b1;
		end else if (touch_ready) begin
			touch_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			position_q <= POS_W'(pos_wrap);
			count_q    <= COUNT_W'(cur_q.length);
			sum_q      <= SUM_W'(cur_q.pressure);
			zero_q     <= zero;
			last_run_q <= last_q;
		end
	end

	assign touch_valid   = touch_valid_q;
	assign position_q8   = position_q;
	assign channel_count = count_q;
	assign pressure_sum  = sum_q;
	assign zero_pressure = zero_q;
	assign last_of_run   = last_run_q;

endmodule
`default_nettype wire

// File: verif/touch_centroid_check.sv
module touch_centroid_check import tsc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	input  logic                sample_ready,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic [INDEX_W-1:0]  frame_start,
	input  logic [INDEX_W-1:0]  chan_offset,
	input  logic                last_in_frame,
	input  logic                touch_valid,
	input  logic                touch_ready,
	input  logic [POS_W-1:0]    position_q8,
	input  logic [COUNT_W-1:0]  channel_count,
	input  logic [SUM_W-1:0]    pressure_sum,
	input  logic                zero_pressure,
	input  logic                last_of_run,
	output int                  mismatches,
	output int                  touches_pending,
	output int                  touches_checked,
	output int                  zero_touches,
	output int                  paired_touches,
	output int                  cut_frames
);

	typedef struct packed {
		logic [POS_W-1:0]   position;
		logic [COUNT_W-1:0] count;
		logic [SUM_W-1:0]   sum;
		logic               zero;
		logic               last;
	} touch_t;

	touch_t expected_touches[$];
	touch_t oldest;

	// segment and frame tracking
	logic [PRESS_BITS-1:0]  acc_pressure;
	logic [WEIGHT_BITS-1:0] acc_weighted;
	logic [LEN_BITS-1:0]    acc_len;
	logic [START_BITS-1:0]  base_channel;
	logic [SAMPLE_BITS-1:0] peak_level;
	logic [IDX_BITS-1:0]    peak_idx;
	logic                   peak_valid;
	logic [SAMPLE_BITS-1:0] last_level;
	logic [IDX_BITS-1:0]    chan_idx;
	logic [INDEX_W-1:0]     frame_shift;
	logic                   frame_open;

	function automatic touch_t close_segment();
		longint unsigned pos;
		longint unsigned offset;
		longint unsigned wt;
		touch_t t;
		pos = 0;
		wt = 64'(acc_weighted);
		if (acc_pressure != 0)
			pos = (wt << FRAC_BITS) / acc_pressure;
		offset = 64'(base_channel);
		offset = (offset + 64'(frame_shift)) << FRAC_BITS;
		pos += offset;
		// wrap once around the channel ring
		if (pos >= (NUM_CHANNELS << FRAC_BITS))
			pos -= (NUM_CHANNELS << FRAC_BITS);
		t.position = pos[POS_W-1:0];
		t.count    = acc_len;
		t.sum      = acc_pressure;
		t.zero     = (acc_pressure == 0);
		t.last     = 1'b0;
		return t;
	endfunction

	task automatic predict_touches(input logic [SAMPLE_W-1:0] s, input logic [INDEX_W-1:0] fs,
			input logic [INDEX_W-1:0] sc, input logic lf);
		logic [SAMPLE_BITS-1:0] v;
		touch_t made[2];
		int n;
		v = s[SAMPLE_BITS-1:0];
		n = 0;
		if (!frame_open) begin
			base_channel = START_BITS'(fs);
			frame_shift  = sc;
			chan_idx     = '0;
			peak_valid   = 1'b0;
			peak_level   = '0;
			peak_idx     = '0;
			last_level   = '0;
			acc_pressure = '0;
			acc_weighted = '0;
			acc_len      = '0;
			frame_open   = 1'b1;
		end
		if (!peak_valid || (peak_idx + 1 == chan_idx && v >= peak_level)) begin
			peak_level = v;
			peak_idx   = chan_idx;
			peak_valid = 1'b1;
			last_level = v;
		end else if (peak_idx + 1 != chan_idx && v > last_level) begin
			// valley: close the segment, the valley opens the next one
			made[n] = close_segment();
			n++;
			base_channel = base_channel + START_BITS'(acc_len) - START_BITS'(1);
			acc_pressure = PRESS_BITS'(last_level);
			acc_weighted = '0;
			acc_len      = LEN_BITS'(1);
			peak_valid   = 1'b0;
			peak_level   = '0;
			last_level   = '0;
		end else begin
			last_level = v;
		end
		acc_weighted = acc_weighted + WEIGHT_BITS'(acc_len) * WEIGHT_BITS'(v);
		acc_pressure = acc_pressure + PRESS_BITS'(v);
		acc_len      = acc_len + 1'b1;
		chan_idx     = chan_idx + 1'b1;
		if (lf || chan_idx >= NUM_CHANNELS) begin
			if (!lf)
				cut_frames++;
			made[n] = close_segment();
			n++;
			frame_open = 1'b0;
		end
		if (n > 0)
			made[n-1].last = 1'b1;
		if (n == 2)
			paired_touches++;
		for (int k = 0; k < n; k++) begin
			if (made[k].zero)
				zero_touches++;
			expected_touches.insert(expected_touches.size(), made[k]);
		end
	endtask

	task automatic check_field(input string field, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_touches.delete();
			frame_open      = 1'b0;
			acc_pressure    = '0;
			acc_weighted    = '0;
			acc_len         = '0;
			base_channel    = '0;
			peak_level      = '0;
			peak_idx        = '0;
			peak_valid      = 1'b0;
			last_level      = '0;
			chan_idx        = '0;
			frame_shift     = '0;
			mismatches      = 0;
			touches_checked = 0;
			zero_touches    = 0;
			paired_touches  = 0;
			cut_frames      = 0;
			touches_pending <= 0;
		end else begin
			if (touch_valid && touch_ready) begin
				if (expected_touches.size() == 0) begin
					$error("unexpected touch transaction: position_q8 %0d, channel_count %0d",
						position_q8, channel_count);
					mismatches++;
				end else begin
					oldest = expected_touches.pop_front();
					check_field("position_q8", oldest.position, position_q8);
					check_field("channel_count", oldest.count, channel_count);
					check_field("pressure_sum", oldest.sum, pressure_sum);
					check_field("zero_pressure", oldest.zero, zero_pressure);
					check_field("last_of_run", oldest.last, last_of_run);
					touches_checked++;
				end
			end
			if (sample_valid && sample_ready)
				predict_touches(sample, frame_start, chan_offset, last_in_frame);
			touches_pending <= expected_touches.size();
		end
	end

endmodule

// File: verif/tb_touch_segment_centroid.sv
module tb_touch_segment_centroid import tsc_pkg::*; ();

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;
	localparam int ITEM_COUNT  = 550;

	typedef enum int {SHAPE_HILLS, SHAPE_NOISE, SHAPE_LOW, SHAPE_FULL} frame_shape_t;

	logic                clk;
	logic                arst_n        = 1'b0;
	logic                sample_valid  = 1'b0;
	logic                sample_ready;
	logic [SAMPLE_W-1:0] sample        = '0;
	logic [INDEX_W-1:0]  frame_start   = '0;
	logic [INDEX_W-1:0]  chan_offset   = '0;
	logic                last_in_frame = 1'b0;
	logic                touch_valid;
	logic                touch_ready   = 1'b0;
	logic [POS_W-1:0]    position_q8;
	logic [COUNT_W-1:0]  channel_count;
	logic [SUM_W-1:0]    pressure_sum;
	logic                zero_pressure;
	logic                last_of_run;

	int mismatches;
	int touches_pending;
	int touches_checked;
	int zero_touches;
	int paired_touches;
	int cut_frames;

	bit hold_req = 1'b0;
	bit calm     = 1'b0;
	int sent     = 0;
	int frames   = 0;
	int cycle_count = 0;

	touch_segment_centroid i_dut (.*);

	touch_centroid_check i_touch_check (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL touch_segment_centroid");
		$finish;
	end

	// receiver: random stalls, one long hold-off, none once calm
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				touch_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				touch_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				touch_ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic [INDEX_W-1:0] fs,
			input logic [INDEX_W-1:0] sc, input logic lf);
		if (!calm && $urandom_range(0, 4) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		sample_valid  <= 1'b1;
		sample        <= s;
		frame_start   <= fs;
		chan_offset   <= sc;
		last_in_frame <= lf;
		do @(posedge clk); while (!sample_ready);
		sent++;
	endtask

	// frame_start and chan_offset vary on every sample; only the first one counts
	task automatic send_frame(input int len, input frame_shape_t shape, input bit close);
		logic [SAMPLE_W-1:0] level;
		bit rising;
		level  = '0;
		rising = 1'b1;
		for (int k = 0; k < len; k++) begin
			case (shape)
				SHAPE_NOISE: begin
					if ($urandom_range(0, 7) == 0)
						level = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
					else
						level = SAMPLE_W'($urandom);
				end
				SHAPE_LOW:  level = SAMPLE_W'($urandom_range(0, 2));
				SHAPE_FULL: level = 12'hFFF;
				default: begin
					if ($urandom_range(0, 3) == 0)
						rising = !rising;
					if (rising)
						level = SAMPLE_W'($urandom_range(level, 12'hFFF));
					else
						level = SAMPLE_W'($urandom_range(0, level));
				end
			endcase
			send_sample(level, INDEX_W'($urandom_range(0, 63)), INDEX_W'($urandom_range(0, 63)),
				close && k == len - 1);
		end
		frames++;
	endtask

	initial begin
		int pick;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all-zero frame at the top of the channel range, wraps with no centroid
		send_sample(12'd0, 6'd63, 6'd63, 1'b0);
		send_sample(12'd0, 6'd0, 6'd0, 1'b1);
		// valley and frame end on the same sample
		send_sample(12'd100, 6'd0, 6'd0, 1'b0);
		send_sample(12'd4095, 6'd63, 6'd63, 1'b0);
		send_sample(12'd200, 6'd0, 6'd0, 1'b0);
		send_sample(12'd50, 6'd0, 6'd0, 1'b0);
		send_sample(12'd300, 6'd0, 6'd0, 1'b1);
		// plateau peak, valley, then the next sample restarts the peak
		send_sample(12'd4095, 6'd40, 6'd50, 1'b0);
		send_sample(12'd4095, 6'd0, 6'd0, 1'b0);
		send_sample(12'd1, 6'd0, 6'd0, 1'b0);
		send_sample(12'd4095, 6'd0, 6'd0, 1'b0);
		send_sample(12'd0, 6'd0, 6'd0, 1'b0);
		send_sample(12'd4095, 6'd0, 6'd0, 1'b1);
		// single-sample frame
		send_sample(12'd4095, 6'd0, 6'd63, 1'b1);
		// equal values on the fall are not a valley
		send_sample(12'd10, 6'd21, 6'd42, 1'b0);
		send_sample(12'd20, 6'd42, 6'd21, 1'b0);
		send_sample(12'd5, 6'd0, 6'd0, 1'b0);
		send_sample(12'd5, 6'd0, 6'd0, 1'b0);
		send_sample(12'd9, 6'd0, 6'd0, 1'b1);
		frames += 5;

		// full-scale frame cut at the channel limit
		send_frame(NUM_CHANNELS, SHAPE_FULL, 1'b0);

		while (sent < ITEM_COUNT) begin
			if (sent >= 200)
				hold_req <= 1'b1;
			if (sent >= 470)
				calm <= 1'b1;
			pick = $urandom_range(0, 15);
			if (pick == 0)
				send_frame($urandom_range(NUM_CHANNELS, NUM_CHANNELS + 3), SHAPE_HILLS, 1'b0);
			else if (pick <= 2)
				send_frame($urandom_range(1, 12), SHAPE_NOISE, 1'($urandom_range(0, 1)));
			else if (pick == 3)
				send_frame($urandom_range(1, 8), SHAPE_LOW, 1'b1);
			else
				send_frame($urandom_range(2, 24), SHAPE_HILLS, 1'b1);
		end
		sample_valid <= 1'b0;

		@(posedge clk);
		while (touches_pending != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);

		$display("Covered %0d samples over %0d frames; %0d touches compared, %0d with zero pressure.",
			sent, frames, touches_checked, zero_touches);
		$display("%0d samples closed a valley and a frame together; %0d frames hit the channel limit.",
			paired_touches, cut_frames);
		if (mismatches == 0 && touches_pending == 0)
			$display("PASS touch_segment_centroid");
		else
			$display("FAIL touch_segment_centroid");
		$finish;
	end

endmodule
